>>> hw/rtl/fortran_free_format_lexer_core_defines.svh
// Assertion helpers shared by the lexer RTL.
`ifndef FORTRAN_FREE_FORMAT_LEXER_CORE_DEFINES_SVH
`define FORTRAN_FREE_FORMAT_LEXER_CORE_DEFINES_SVH

// Condition must hold on every clock edge outside reset.
`define FFL_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define FFL_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/fflex_pkg.sv
package fflex_pkg;

  // Scan modes between characters
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_IDENT   = 4'd1;
  localparam logic [3:0] M_INT     = 4'd2;
  localparam logic [3:0] M_INTDOT  = 4'd3;
  localparam logic [3:0] M_REAL    = 4'd4;
  localparam logic [3:0] M_REALEXP = 4'd5;
  localparam logic [3:0] M_STR     = 4'd6;
  localparam logic [3:0] M_STRQ    = 4'd7;
  localparam logic [3:0] M_DOT     = 4'd8;
  localparam logic [3:0] M_DOTOP   = 4'd9;
  localparam logic [3:0] M_STAR    = 4'd10;
  localparam logic [3:0] M_SKIP    = 4'd11;

  // Token kinds
  localparam logic [5:0] K_ERROR   = 6'd0;
  localparam logic [5:0] K_NEWLINE = 6'd1;
  localparam logic [5:0] K_INT     = 6'd2;
  localparam logic [5:0] K_REALLIT = 6'd3;
  localparam logic [5:0] K_STRING  = 6'd4;
  localparam logic [5:0] K_IDENT   = 6'd5;
  localparam logic [5:0] K_PLUS    = 6'd6;
  localparam logic [5:0] K_MINUS   = 6'd7;
  localparam logic [5:0] K_STAR    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_POWER   = 6'd10;
  localparam logic [5:0] K_LPAREN  = 6'd22;
  localparam logic [5:0] K_RPAREN  = 6'd23;
  localparam logic [5:0] K_COMMA   = 6'd24;
  localparam logic [5:0] K_COLON   = 6'd25;
  localparam logic [5:0] K_ASSIGN  = 6'd26;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_D     = 8'h44;

  // Keyword table
  localparam int KW_COUNT = 34;
  localparam int KW_MAX   = 10;

  typedef struct packed {
    logic [8*KW_MAX-1:0] word;  // space padded, first char in top byte
    logic [3:0]          len;
    logic [5:0]          kind;
  } kw_ent_t;

  function automatic kw_ent_t kw_entry(input logic [5:0] idx);
    kw_ent_t e;
    e = '{word: "          ", len: 4'd0, kind: K_IDENT};
    case (idx)
      6'd0:  e = '{word: "AND       ", len: 4'd3,  kind: 6'd17};
      6'd1:  e = '{word: "CALL      ", len: 4'd4,  kind: 6'd45};
      6'd2:  e = '{word: "COMMON    ", len: 4'd6,  kind: 6'd47};
      6'd3:  e = '{word: "CONTINUE  ", len: 4'd8,  kind: 6'd38};
      6'd4:  e = '{word: "DATA      ", len: 4'd4,  kind: 6'd48};
      6'd5:  e = '{word: "DIMENSION ", len: 4'd9,  kind: 6'd32};
      6'd6:  e = '{word: "DO        ", len: 4'd2,  kind: 6'd37};
      6'd7:  e = '{word: "ELSE      ", len: 4'd4,  kind: 6'd35};
      6'd8:  e = '{word: "END       ", len: 4'd3,  kind: 6'd28};
      6'd9:  e = '{word: "ENDIF     ", len: 4'd5,  kind: 6'd36};
      6'd10: e = '{word: "EQ        ", len: 4'd2,  kind: 6'd11};
      6'd11: e = '{word: "FALSE     ", len: 4'd5,  kind: 6'd21};
      6'd12: e = '{word: "FORMAT    ", len: 4'd6,  kind: 6'd49};
      6'd13: e = '{word: "FUNCTION  ", len: 4'd8,  kind: 6'd44};
      6'd14: e = '{word: "GE        ", len: 4'd2,  kind: 6'd16};
      6'd15: e = '{word: "GOTO      ", len: 4'd4,  kind: 6'd39};
      6'd16: e = '{word: "GT        ", len: 4'd2,  kind: 6'd14};
      6'd17: e = '{word: "IF        ", len: 4'd2,  kind: 6'd33};
      6'd18: e = '{word: "INTEGER   ", len: 4'd7,  kind: 6'd29};
      6'd19: e = '{word: "LE        ", len: 4'd2,  kind: 6'd15};
      6'd20: e = '{word: "LOGICAL   ", len: 4'd7,  kind: 6'd31};
      6'd21: e = '{word: "LT        ", len: 4'd2,  kind: 6'd13};
      6'd22: e = '{word: "NE        ", len: 4'd2,  kind: 6'd12};
      6'd23: e = '{word: "NOT       ", len: 4'd3,  kind: 6'd19};
      6'd24: e = '{word: "OR        ", len: 4'd2,  kind: 6'd18};
      6'd25: e = '{word: "PROGRAM   ", len: 4'd7,  kind: 6'd27};
      6'd26: e = '{word: "READ      ", len: 4'd4,  kind: 6'd41};
      6'd27: e = '{word: "REAL      ", len: 4'd4,  kind: 6'd30};
      6'd28: e = '{word: "RETURN    ", len: 4'd6,  kind: 6'd46};
      6'd29: e = '{word: "STOP      ", len: 4'd4,  kind: 6'd42};
      6'd30: e = '{word: "SUBROUTINE", len: 4'd10, kind: 6'd43};
      6'd31: e = '{word: "THEN      ", len: 4'd4,  kind: 6'd34};
      6'd32: e = '{word: "TRUE      ", len: 4'd4,  kind: 6'd20};
      6'd33: e = '{word: "WRITE     ", len: 4'd5,  kind: 6'd40};
      default: e = '{word: "          ", len: 4'd0, kind: K_IDENT};
    endcase
    return e;
  endfunction

  // Character classes
  function automatic logic alpha_chr(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
  endfunction

  function automatic logic digit_chr(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return c == CH_NUL || c == CH_NL;
  endfunction

  function automatic logic [7:0] upper_chr(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
  endfunction

endpackage

>>> hw/rtl/fflex_kw_cmp.sv
module fflex_kw_cmp
  import fflex_pkg::*;
#(
  parameter int IDENT_LEN = 8,
  parameter int NL_W      = 4
) (
  input  logic [5:0]             kw_idx,
  input  logic [IDENT_LEN*8-1:0] name,     // char 0 in lowest byte
  input  logic [NL_W-1:0]        name_len,
  output logic                   hit,
  output logic [5:0]             kind
);

  kw_ent_t           ent;
  logic [KW_MAX-1:0] byte_ok;

  assign ent = kw_entry(kw_idx);

  // Per-position compare; positions past the word length always pass
  for (genvar j = 0; j < KW_MAX; j++) begin : g_byte
    if (j < IDENT_LEN) begin : g_cmp
      assign byte_ok[j] = (4'(j) >= ent.len) ||
                          (name[8*j +: 8] == ent.word[8*(KW_MAX-1-j) +: 8]);
    end else begin : g_pass
      assign byte_ok[j] = 1'b1;
    end
  end

  assign hit  = (6'(name_len) == 6'(ent.len)) && (&byte_ok);
  assign kind = ent.kind;

endmodule

>>> hw/rtl/fortran_free_format_lexer_core.sv
// An accepted character is registered and decided in S_DECIDE, and its result items
// pass through the output register; a keyword lookup scans the 34-entry table
// through one shared compare unit, one entry per cycle.
// A new character is accepted only in S_WAIT, once the lookup scan and the text runs,
// which leave one character per cycle while the output is not stalled, are done.
// Reset (synchronous, rst_n low): scanner idle, counters zero, no item held.
`include "fortran_free_format_lexer_core_defines.svh"

module fortran_free_format_lexer_core
  import fflex_pkg::*;
#(
  parameter int IDENT_LEN     = 8,
  parameter int STRING_LEN    = 64,
  parameter int REAL_TEXT_LEN = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] int_value, [23:16] text_char
  output logic [6:0]  out_tuser,  // [5:0] token_kind, [6] text_valid
  output logic        out_tlast   // run_last
);

  localparam int NL_W  = $clog2(IDENT_LEN + 1);
  localparam int RL_W  = $clog2(REAL_TEXT_LEN + 1);
  localparam int SL_W  = $clog2(STRING_LEN + 1);
  localparam int NI_W  = (IDENT_LEN > 1) ? $clog2(IDENT_LEN) : 1;
  localparam int RI_W  = $clog2(REAL_TEXT_LEN);
  localparam int RUN_W = (NL_W > RL_W) ? NL_W : RL_W;

  typedef enum logic [5:0] {
    S_WAIT   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_KWOUT  = 6'b001000,
    S_RUN    = 6'b010000,
    S_STRCAP = 6'b100000
  } seq_t;

  typedef enum logic [2:0] {
    NX_DONE,
    NX_REDO,
    NX_LOOKUP,
    NX_RUNREAL,
    NX_STRCAP
  } nx_t;

  seq_t             state_r, state_nxt;
  logic [3:0]       mode_r, mode_nxt;
  logic [7:0]       char_r, char_nxt;
  logic [7:0]       saved_r;
  logic             replay_r, replay_nxt;
  logic [7:0]       nbuf_r [IDENT_LEN];
  logic [NL_W-1:0]  nlen_r, nlen_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [7:0]       rbuf_r [REAL_TEXT_LEN];
  logic [RL_W-1:0]  rlen_r, rlen_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [SL_W-1:0]  slen_r, slen_nxt;
  logic [5:0]       kw_idx_r, kw_idx_nxt;
  logic [5:0]       kw_kind_r, kw_kind_nxt;
  logic             dotted_r, dotted_nxt;
  logic             src_real_r, src_real_nxt;
  logic [RUN_W-1:0] idx_r, idx_nxt;

  logic        out_valid_r;
  logic [5:0]  out_kind_r;
  logic [15:0] out_ival_r;
  logic [7:0]  out_chr_r;
  logic        out_val_r;
  logic        out_last_r;

  // Decide-step results
  logic            d_emit;
  logic [5:0]      d_kind;
  logic [15:0]     d_ival;
  logic [7:0]      d_chr;
  logic            d_val;
  logic            d_last;
  logic [3:0]      d_mode;
  nx_t             d_next;
  logic            nb_we;
  logic [NI_W-1:0] nb_wi;
  logic [7:0]      nb_wd;
  logic            rb_we;
  logic [RI_W-1:0] rb_wi;
  logic [7:0]      rb_wd;
  logic [NL_W-1:0] d_nlen;
  logic [RL_W-1:0] d_rlen;
  logic [15:0]     d_acc;
  logic [SL_W-1:0] d_slen;
  logic [7:0]      d_held;
  logic [7:0]      d_char;
  logic            d_replay;

  logic        do_real, do_sadd, do_send;
  logic        room;
  logic [7:0]  c, u;
  logic [15:0] acc_x10;
  logic        slot_free;

  // Emit mux
  logic        e_en;
  logic [5:0]  e_kind;
  logic [15:0] e_ival;
  logic [7:0]  e_chr;
  logic        e_val;
  logic        e_last;

  logic [IDENT_LEN*8-1:0] name_flat;
  logic                   kw_hit;
  logic [5:0]             kw_kind;
  logic [RUN_W-1:0]       run_len;
  logic                   run_end;
  logic [7:0]             run_chr;

  assign c         = char_r;
  assign u         = upper_chr(char_r);
  assign room      = rlen_r < RL_W'(REAL_TEXT_LEN);
  assign acc_x10   = (acc_r << 3) + (acc_r << 1);
  assign slot_free = !out_valid_r || out_tready;

  for (genvar i = 0; i < IDENT_LEN; i++) begin : g_flat
    assign name_flat[8*i +: 8] = nbuf_r[i];
  end

  // Shared keyword compare unit, one table entry per cycle
  fflex_kw_cmp #(
    .IDENT_LEN (IDENT_LEN),
    .NL_W      (NL_W)
  ) u_kw_cmp (
    .kw_idx   (kw_idx_r),
    .name     (name_flat),
    .name_len (nlen_r),
    .hit      (kw_hit),
    .kind     (kw_kind)
  );

  // Run source
  assign run_len = src_real_r ? RUN_W'(rlen_r) : RUN_W'(nlen_r);
  assign run_end = (idx_r + RUN_W'(1)) == run_len;
  assign run_chr = src_real_r ? rbuf_r[idx_r[RI_W-1:0]] : nbuf_r[idx_r[NI_W-1:0]];

  // One scanner step for the current character
  always_comb begin
    d_emit   = 1'b0;
    d_kind   = K_ERROR;
    d_ival   = '0;
    d_chr    = '0;
    d_val    = 1'b0;
    d_last   = 1'b1;
    d_mode   = mode_r;
    d_next   = NX_DONE;
    nb_we    = 1'b0;
    nb_wi    = nlen_r[NI_W-1:0];
    nb_wd    = u;
    rb_we    = 1'b0;
    rb_wi    = rlen_r[RI_W-1:0];
    rb_wd    = c;
    d_nlen   = nlen_r;
    d_rlen   = rlen_r;
    d_acc    = acc_r;
    d_slen   = slen_r;
    d_held   = held_r;
    d_char   = char_r;
    d_replay = replay_r;
    do_real  = 1'b0;
    do_sadd  = 1'b0;
    do_send  = 1'b0;
    unique case (mode_r)
      M_IDENT: begin
        if (alpha_chr(c) || digit_chr(c)) begin
          if (nlen_r < NL_W'(IDENT_LEN)) begin
            nb_we  = 1'b1;
            d_nlen = nlen_r + NL_W'(1);
          end
        end else begin
          d_next = NX_LOOKUP;
        end
      end
      M_INT: begin
        if (digit_chr(c)) begin
          d_acc = acc_x10 + {12'd0, c[3:0]};
          if (room) begin
            rb_we  = 1'b1;
            d_rlen = rlen_r + RL_W'(1);
          end
        end else if (c == CH_DOT) begin
          d_mode = M_INTDOT;
        end else if (u == CH_E || u == CH_D) begin
          do_real = 1'b1;
        end else begin
          d_emit = 1'b1;
          d_kind = K_INT;
          d_ival = acc_r;
          d_mode = M_IDLE;
          d_next = NX_REDO;
        end
      end
      M_INTDOT: begin
        if (digit_chr(c) || is_eol(c) || c == CH_SPACE || c == CH_PLUS || c == CH_MINUS ||
            c == CH_STAR || c == CH_SLASH || c == CH_RPAR || c == CH_COMMA) begin
          // the dot joins the real first, then this character is scanned again
          d_char   = CH_DOT;
          d_replay = 1'b1;
          d_mode   = M_REAL;
          d_next   = NX_REDO;
        end else begin
          d_emit = 1'b1;
          d_kind = K_INT;
          d_ival = acc_r;
          d_mode = M_DOT;
          d_next = NX_REDO;
        end
      end
      M_REALEXP: begin
        if (c == CH_PLUS || c == CH_MINUS) begin
          if (room) begin
            rb_we  = 1'b1;
            d_rlen = rlen_r + RL_W'(1);
            d_mode = M_REAL;
          end else begin
            d_next = NX_RUNREAL;
          end
        end else begin
          do_real = 1'b1;
        end
      end
      M_REAL: do_real = 1'b1;
      M_STR: begin
        if (is_eol(c)) do_send = 1'b1;
        else if (c == CH_QUOTE) d_mode = M_STRQ;
        else do_sadd = 1'b1;
      end
      M_STRQ: begin
        if (c == CH_QUOTE) begin
          d_mode  = M_STR;
          do_sadd = 1'b1;
        end else begin
          do_send = 1'b1;
        end
      end
      M_DOT: begin
        if (alpha_chr(c)) begin
          nb_we  = 1'b1;
          nb_wi  = '0;
          d_nlen = NL_W'(1);
          d_mode = M_DOTOP;
        end else begin
          d_emit = 1'b1;
          d_mode = M_IDLE;
          d_next = NX_REDO;
        end
      end
      M_DOTOP: begin
        if (alpha_chr(c) && nlen_r < NL_W'(IDENT_LEN)) begin
          nb_we  = 1'b1;
          d_nlen = nlen_r + NL_W'(1);
        end else if (c == CH_DOT) begin
          d_next = NX_LOOKUP;
        end else begin
          d_emit = 1'b1;
          d_mode = M_IDLE;
          d_next = NX_REDO;
        end
      end
      M_STAR: begin
        d_emit = 1'b1;
        d_mode = M_IDLE;
        if (c == CH_STAR) begin
          d_kind = K_POWER;
        end else begin
          d_kind = K_STAR;
          d_next = NX_REDO;
        end
      end
      M_SKIP: begin
        if (is_eol(c)) begin
          d_mode = M_IDLE;
          d_next = NX_REDO;
        end
      end
      default: begin
        // between tokens
        d_mode = M_IDLE;
        if (is_eol(c)) begin
          d_emit = 1'b1;
          d_kind = K_NEWLINE;
        end else if (c == CH_SPACE || c == CH_TAB) begin
          d_emit = 1'b0;
        end else if (c == CH_BANG) begin
          d_mode = M_SKIP;
        end else if (digit_chr(c)) begin
          d_acc  = {12'd0, c[3:0]};
          rb_we  = 1'b1;
          rb_wi  = '0;
          d_rlen = RL_W'(1);
          d_mode = M_INT;
        end else if (alpha_chr(c)) begin
          nb_we  = 1'b1;
          nb_wi  = '0;
          d_nlen = NL_W'(1);
          d_mode = M_IDENT;
        end else begin
          case (c)
            CH_QUOTE: begin
              d_slen = '0;
              d_mode = M_STR;
            end
            CH_DOT:  d_mode = M_DOT;
            CH_STAR: d_mode = M_STAR;
            default: begin
              d_emit = 1'b1;
              case (c)
                CH_PLUS:  d_kind = K_PLUS;
                CH_MINUS: d_kind = K_MINUS;
                CH_SLASH: d_kind = K_SLASH;
                CH_LPAR:  d_kind = K_LPAREN;
                CH_RPAR:  d_kind = K_RPAREN;
                CH_COMMA: d_kind = K_COMMA;
                CH_COLON: d_kind = K_COLON;
                CH_EQ:    d_kind = K_ASSIGN;
                default:  d_kind = K_ERROR;
              endcase
            end
          endcase
        end
      end
    endcase

    // Add a character to a real, or close it
    if (do_real) begin
      if (room && (digit_chr(c) || c == CH_DOT)) begin
        rb_we  = 1'b1;
        d_rlen = rlen_r + RL_W'(1);
        d_mode = M_REAL;
      end else if (room && (u == CH_E || u == CH_D)) begin
        rb_we  = 1'b1;
        rb_wd  = CH_E;
        d_rlen = rlen_r + RL_W'(1);
        d_mode = M_REALEXP;
      end else begin
        d_next = NX_RUNREAL;
      end
    end

    // String character: the held one leaves, this one is held
    if (do_sadd) begin
      if (slen_r != '0) begin
        d_emit = 1'b1;
        d_kind = K_STRING;
        d_chr  = held_r;
        d_val  = 1'b1;
        d_last = 1'b0;
      end
      d_held = c;
      d_slen = slen_r + SL_W'(1);
      if ((slen_r + SL_W'(1)) >= SL_W'(STRING_LEN)) d_next = NX_STRCAP;
    end

    // String close
    if (do_send) begin
      d_emit = 1'b1;
      d_kind = K_STRING;
      d_chr  = (slen_r != '0) ? held_r : 8'd0;
      d_val  = slen_r != '0;
      d_mode = M_IDLE;
      d_next = NX_REDO;
    end
  end

  // Select what goes to the output register
  always_comb begin
    e_en   = 1'b0;
    e_kind = K_ERROR;
    e_ival = '0;
    e_chr  = '0;
    e_val  = 1'b0;
    e_last = 1'b1;
    unique case (state_r)
      S_DECIDE: begin
        e_en   = d_emit;
        e_kind = d_kind;
        e_ival = d_ival;
        e_chr  = d_chr;
        e_val  = d_val;
        e_last = d_last;
      end
      S_KWOUT: begin
        if (dotted_r) begin
          e_en   = 1'b1;
          e_kind = (kw_kind_r == K_IDENT) ? K_ERROR : kw_kind_r;
        end else if (kw_kind_r != K_IDENT) begin
          e_en   = 1'b1;
          e_kind = kw_kind_r;
        end
      end
      S_RUN: begin
        e_en   = 1'b1;
        e_kind = src_real_r ? K_REALLIT : K_IDENT;
        e_chr  = run_chr;
        e_val  = 1'b1;
        e_last = run_end;
      end
      S_STRCAP: begin
        e_en   = 1'b1;
        e_kind = K_STRING;
        e_chr  = held_r;
        e_val  = 1'b1;
      end
      default: e_en = 1'b0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    char_nxt     = char_r;
    replay_nxt   = replay_r;
    nlen_nxt     = nlen_r;
    acc_nxt      = acc_r;
    rlen_nxt     = rlen_r;
    held_nxt     = held_r;
    slen_nxt     = slen_r;
    kw_idx_nxt   = kw_idx_r;
    kw_kind_nxt  = kw_kind_r;
    dotted_nxt   = dotted_r;
    src_real_nxt = src_real_r;
    idx_nxt      = idx_r;
    unique case (state_r)
      S_WAIT: begin
        if (in_tvalid) begin
          char_nxt  = in_tdata;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!d_emit || slot_free) begin
          mode_nxt   = d_mode;
          char_nxt   = d_char;
          replay_nxt = d_replay;
          nlen_nxt   = d_nlen;
          acc_nxt    = d_acc;
          rlen_nxt   = d_rlen;
          held_nxt   = d_held;
          slen_nxt   = d_slen;
          case (d_next)
            NX_REDO: state_nxt = S_DECIDE;
            NX_LOOKUP: begin
              kw_idx_nxt = '0;
              dotted_nxt = mode_r == M_DOTOP;
              state_nxt  = S_LOOKUP;
            end
            NX_RUNREAL: begin
              idx_nxt      = '0;
              src_real_nxt = 1'b1;
              state_nxt    = S_RUN;
            end
            NX_STRCAP: state_nxt = S_STRCAP;
            default: begin
              if (replay_r) begin
                char_nxt   = saved_r;
                replay_nxt = 1'b0;
                state_nxt  = S_DECIDE;
              end else begin
                state_nxt = S_WAIT;
              end
            end
          endcase
        end
      end
      S_LOOKUP: begin
        if (kw_hit) begin
          kw_kind_nxt = kw_kind;
          state_nxt   = S_KWOUT;
        end else if (kw_idx_r == 6'(KW_COUNT - 1)) begin
          kw_kind_nxt = K_IDENT;
          state_nxt   = S_KWOUT;
        end else begin
          kw_idx_nxt = kw_idx_r + 6'd1;
        end
      end
      S_KWOUT: begin
        if (!e_en) begin
          idx_nxt      = '0;
          src_real_nxt = 1'b0;
          state_nxt    = S_RUN;
        end else if (slot_free) begin
          mode_nxt = M_IDLE;
          if (!dotted_r) begin
            state_nxt = S_DECIDE;
          end else if (replay_r) begin
            char_nxt   = saved_r;
            replay_nxt = 1'b0;
            state_nxt  = S_DECIDE;
          end else begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_RUN: begin
        if (slot_free) begin
          if (run_end) begin
            mode_nxt  = M_IDLE;
            state_nxt = S_DECIDE;
          end else begin
            idx_nxt = idx_r + RUN_W'(1);
          end
        end
      end
      S_STRCAP: begin
        if (slot_free) begin
          mode_nxt = M_IDLE;
          if (replay_r) begin
            char_nxt   = saved_r;
            replay_nxt = 1'b0;
            state_nxt  = S_DECIDE;
          end else begin
            state_nxt = S_WAIT;
          end
        end
      end
      default: state_nxt = S_WAIT;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WAIT;
      mode_r      <= M_IDLE;
      replay_r    <= 1'b0;
      nlen_r      <= '0;
      acc_r       <= '0;
      rlen_r      <= '0;
      held_r      <= '0;
      slen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      replay_r <= replay_nxt;
      nlen_r   <= nlen_nxt;
      acc_r    <= acc_nxt;
      rlen_r   <= rlen_nxt;
      held_r   <= held_nxt;
      slen_r   <= slen_nxt;
      if (slot_free) out_valid_r <= e_en;
    end
  end

  // Payload and buffers
  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    kw_idx_r   <= kw_idx_nxt;
    kw_kind_r  <= kw_kind_nxt;
    dotted_r   <= dotted_nxt;
    src_real_r <= src_real_nxt;
    idx_r      <= idx_nxt;
    if (state_r == S_WAIT && in_tvalid) saved_r <= in_tdata;
    if (state_r == S_DECIDE && (!d_emit || slot_free)) begin
      if (nb_we) nbuf_r[nb_wi] <= nb_wd;
      if (rb_we) rbuf_r[rb_wi] <= rb_wd;
    end
    if (slot_free && e_en) begin
      out_kind_r <= e_kind;
      out_ival_r <= e_ival;
      out_chr_r  <= e_chr;
      out_val_r  <= e_val;
      out_last_r <= e_last;
    end
  end

  assign in_tready  = state_r == S_WAIT;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_chr_r, out_ival_r};
  assign out_tuser  = {out_val_r, out_kind_r};
  assign out_tlast  = out_last_r;

  // Checks
  `FFL_CHECK(a_nlen_range, nlen_r <= NL_W'(IDENT_LEN), "name length past limit")
  `FFL_CHECK(a_rlen_range, rlen_r <= RL_W'(REAL_TEXT_LEN), "real text length past limit")
  `FFL_IMPLY(a_run_bound, state_r == S_RUN, idx_r < run_len && run_len != '0, "run index out of range")
  `FFL_IMPLY(a_ready_clean, in_tready, !replay_r, "ready while a character is pending")

endmodule
